@@ rtl/mlkpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mlkpc_pkg;

   localparam int unsigned COEFF_W = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VAL_W   = 12;
   localparam int unsigned SYM_W   = 12;
   localparam int unsigned ACC_W   = 24;
   localparam int unsigned CNT_W   = 5;

   // symbol queue between front and back
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);
   // queue fill plus the two front stages
   localparam int unsigned Q_LVL_W = Q_CNT_W + 1;

   // control register port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FORMAT    = 2'd1;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [1:0] FMT_PLAIN = 2'd0;
   localparam logic [1:0] FMT_DU10  = 2'd1;
   localparam logic [1:0] FMT_DV4   = 2'd2;

   localparam int unsigned Q_MOD  = 3329;
   localparam int unsigned HALF_Q = 1664;

   // mod q of a biased coefficient: quotient estimate by u*314 >> 20, low by at most one
   localparam int unsigned RED_W      = 17;
   localparam int unsigned RED_BIAS   = 33290;
   localparam int unsigned RED_RECIP  = 314;
   localparam int unsigned RED_SHIFT  = 20;
   localparam int unsigned RED_PROD_W = 26;
   localparam int unsigned QH_W       = 5;

   // compress divide by q: exact for numerators below 2^22 with this reciprocal
   localparam int unsigned CMP_W      = 22;
   localparam int unsigned CMP_RECIP  = 5160670;
   localparam int unsigned CMP_SHIFT  = 34;
   localparam int unsigned CMP_PROD_W = 45;
   localparam int unsigned CMP_Q_W    = 11;

   // decompress product width
   localparam int unsigned DC_W = 24;

   typedef struct packed {
      logic       dir;
      logic [1:0] fmt;
   } cfg_type;

   function automatic logic [3:0] group_bits(input logic [1:0] fmt);
      logic [3:0] bits;
      case (fmt)
         FMT_DU10: bits = 4'd10;
         FMT_DV4:  bits = 4'd4;
         default:  bits = 4'd12;
      endcase
      return bits;
   endfunction

   function automatic logic [SYM_W-1:0] group_mask(input logic [1:0] fmt);
      logic [SYM_W-1:0] mask;
      case (fmt)
         FMT_DU10: mask = 12'h3FF;
         FMT_DV4:  mask = 12'h00F;
         default:  mask = 12'hFFF;
      endcase
      return mask;
   endfunction

   function automatic logic is_compressed(input logic [1:0] fmt);
      return (fmt == FMT_DU10) || (fmt == FMT_DV4);
   endfunction

endpackage

`default_nettype wire

@@ rtl/mlkpc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mlkpc_front import mlkpc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COEFF_W-1:0] req_coeff_in,
   input  logic [BYTE_W-1:0]         req_byte_in,
   input  logic [Q_CNT_W-1:0]        q_count,
   output logic                      push,
   output logic [SYM_W-1:0]          push_sym
);

   logic                  accept;
   logic [Q_LVL_W-1:0]    level;
   logic                  s1_v_ff, s1_v_in;
   logic                  s2_v_ff, s2_v_in;
   logic [RED_W-1:0]      s1_u_ff, s1_u_in;
   logic [QH_W-1:0]       s1_qh_ff, s1_qh_in;
   logic [SYM_W-1:0]      s2_sym_ff, s2_sym_in;
   logic [RED_PROD_W-1:0] red_prod;
   logic [RED_W-1:0]      red_sub;
   logic [RED_W-1:0]      red_r;
   logic [CMP_W-1:0]      cmp_num;
   logic [CMP_PROD_W-1:0] cmp_prod;
   logic [CMP_Q_W-1:0]    cmp_q;

   // credit check: everything in flight must find a queue slot
   assign level = Q_LVL_W'(q_count) + Q_LVL_W'(s1_v_ff) + Q_LVL_W'(s2_v_ff);
   assign req_ready = level < Q_LVL_W'(Q_DEPTH);
   assign accept = req_valid && req_ready;

   // stage 1: bias coefficient positive (decode takes the byte as is), estimate quotient by q
   always_comb begin
      if (cfg.dir == DIR_DECODE) begin
         s1_u_in = RED_W'(req_byte_in);
      end else begin
         s1_u_in = RED_W'(req_coeff_in) + RED_W'(RED_BIAS);
      end
      red_prod = RED_PROD_W'(s1_u_in) * RED_PROD_W'(RED_RECIP);
      s1_qh_in = red_prod[RED_SHIFT +: QH_W];
      s1_v_in  = accept;
   end

   // stage 2: remainder with one correction step; decode passes the byte through
   always_comb begin
      red_sub = s1_u_ff - RED_W'(s1_qh_ff) * RED_W'(Q_MOD);
      red_r   = (red_sub >= RED_W'(Q_MOD)) ? red_sub - RED_W'(Q_MOD) : red_sub;
      if (cfg.dir == DIR_DECODE) begin
         s2_sym_in = SYM_W'(s1_u_ff[BYTE_W-1:0]);
      end else begin
         s2_sym_in = red_r[SYM_W-1:0];
      end
      s2_v_in = s1_v_ff;
   end

   // stage 3: rounding compress in encode with a compressed format, written straight into the queue
   always_comb begin
      cmp_num  = (CMP_W'(s2_sym_ff) << group_bits(cfg.fmt)) + CMP_W'(HALF_Q);
      cmp_prod = CMP_PROD_W'(cmp_num) * CMP_PROD_W'(CMP_RECIP);
      cmp_q    = cmp_prod[CMP_SHIFT +: CMP_Q_W];
      if (cfg.dir == DIR_ENCODE && is_compressed(cfg.fmt)) begin
         push_sym = SYM_W'(cmp_q) & group_mask(cfg.fmt);
      end else begin
         push_sym = s2_sym_ff;
      end
   end

   assign push = s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_u_ff   <= s1_u_in;
      s1_qh_ff  <= s1_qh_in;
      s2_sym_ff <= s2_sym_in;
   end

endmodule

`default_nettype wire

@@ rtl/mlkpc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mlkpc_fifo import mlkpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [SYM_W-1:0]   push_sym,
   input  logic               pop,
   output logic [SYM_W-1:0]   head_sym,
   output logic [Q_CNT_W-1:0] count
);

   logic [SYM_W-1:0]   mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   assign head_sym = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_sym;
      end
   end

endmodule

`default_nettype wire

@@ rtl/mlkpc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mlkpc_back import mlkpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               clear,
   input  logic               q_nempty,
   input  logic [SYM_W-1:0]   q_sym,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VAL_W-1:0]   rsp_value_out,
   output logic               rsp_last,
   output logic [CNT_W-1:0]   bit_cnt
);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             last_ff, last_in;

   logic             enc;
   logic [3:0]       d;
   logic [3:0]       thr;
   logic [3:0]       width;
   logic             have;
   logic             merge;
   logic [ACC_W-1:0] mrg_acc, cur_acc;
   logic [CNT_W-1:0] mrg_cnt, cur_cnt, rest_cnt;
   logic             grp_ready;
   logic             out_free;
   logic             emit;
   logic             quiet;
   logic [SYM_W-1:0] dc_t;
   logic [DC_W-1:0]  dc_prod;
   logic [DC_W-1:0]  dc_rnd;
   logic [VAL_W-1:0] dc_val;

   always_comb begin
      enc   = (cfg.dir == DIR_ENCODE);
      d     = group_bits(cfg.fmt);
      // encode drains bytes and fills by groups, decode the other way round
      thr   = enc ? 4'(BYTE_W) : d;
      width = enc ? d : 4'(BYTE_W);

      have  = cnt_ff >= CNT_W'(thr);
      merge = !have && q_nempty;

      mrg_acc = acc_ff | (ACC_W'(q_sym) << cnt_ff);
      mrg_cnt = cnt_ff + CNT_W'(width);
      cur_acc = have ? acc_ff : mrg_acc;
      cur_cnt = have ? cnt_ff : mrg_cnt;

      grp_ready = (have || merge) && (cur_cnt >= CNT_W'(thr));
      out_free  = !rsp_valid_ff || rsp_ready;
      emit      = !clear && grp_ready && out_free;
      // symbol absorbed without completing a result
      quiet     = !clear && merge && !grp_ready;
      rest_cnt  = cur_cnt - CNT_W'(thr);

      q_pop = merge && (emit || quiet);

      if (clear) begin
         acc_in = '0;
         cnt_in = '0;
      end else if (emit) begin
         acc_in = cur_acc >> thr;
         cnt_in = rest_cnt;
      end else if (quiet) begin
         acc_in = mrg_acc;
         cnt_in = mrg_cnt;
      end else begin
         acc_in = acc_ff;
         cnt_in = cnt_ff;
      end
   end

   // decompress: (t*q + 2^(d-1)) >> d
   always_comb begin
      dc_t    = cur_acc[SYM_W-1:0] & group_mask(cfg.fmt);
      dc_prod = DC_W'(dc_t) * DC_W'(Q_MOD);
      dc_rnd  = dc_prod + (DC_W'(1) << (d - 4'd1));
      dc_val  = VAL_W'(dc_rnd >> d);
   end

   always_comb begin
      if (enc) begin
         value_in = VAL_W'(cur_acc[BYTE_W-1:0]);
      end else if (is_compressed(cfg.fmt)) begin
         value_in = dc_val;
      end else begin
         value_in = cur_acc[VAL_W-1:0];
      end
      last_in = rest_cnt < CNT_W'(thr);

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = value_ff;
   assign rsp_last      = last_ff;
   assign bit_cnt       = cnt_ff;

endmodule

`default_nettype wire

@@ rtl/mlkem_poly_compress_pack_codec.sv @@
// path: two front stages (mod-q reduction), one queue slot, then the output register
// throughput: one input item per cycle while credit allows, bounded by one result per
// cycle at the output register while rsp_ready holds; an item that yields two results
// holds the back end until both are emitted
// reset: synchronous; selects encode direction with plain 12-bit format, empties the
// pipeline, the symbol queue and the bit accumulator
`timescale 1ns / 1ps
`default_nettype none

module mlkem_poly_compress_pack_codec import mlkpc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COEFF_W-1:0] req_coeff_in,
   input  logic [BYTE_W-1:0]         req_byte_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [VAL_W-1:0]          rsp_value_out,
   output logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   logic               dir_ff, dir_in;
   logic [1:0]         fmt_ff, fmt_in;
   cfg_type            cfg;
   logic               csr_hit;
   logic               push;
   logic [SYM_W-1:0]   push_sym;
   logic               q_pop;
   logic [SYM_W-1:0]   q_sym;
   logic [Q_CNT_W-1:0] q_count;
   logic [CNT_W-1:0]   bit_cnt;

   // any write to a defined register also drops the pending bits
   always_comb begin
      csr_hit = csr_wr_en && (csr_index == REG_DIRECTION || csr_index == REG_FORMAT);
      dir_in  = dir_ff;
      fmt_in  = fmt_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_DIRECTION: dir_in = csr_wdata[0];
            REG_FORMAT:    fmt_in = csr_wdata[1:0];
            default: begin
               dir_in = dir_ff;
               fmt_in = fmt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_ENCODE;
         fmt_ff <= FMT_PLAIN;
      end else begin
         dir_ff <= dir_in;
         fmt_ff <= fmt_in;
      end
   end

   assign cfg.dir = dir_ff;
   assign cfg.fmt = fmt_ff;

   mlkpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_coeff_in (req_coeff_in),
      .req_byte_in  (req_byte_in),
      .q_count      (q_count),
      .push         (push),
      .push_sym     (push_sym)
   );

   mlkpc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_sym (push_sym),
      .pop      (q_pop),
      .head_sym (q_sym),
      .count    (q_count)
   );

   mlkpc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .clear         (csr_hit),
      .q_nempty      (q_count != '0),
      .q_sym         (q_sym),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_last      (rsp_last),
      .bit_cnt       (bit_cnt)
   );

`ifndef SYNTHESIS
   // credit scheme must never overfill the symbol queue
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= Q_CNT_W'(Q_DEPTH))
      else $error("symbol queue overflow");

   // pending bits stay below one byte plus one widest group
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      bit_cnt < CNT_W'(BYTE_W + SYM_W))
      else $error("bit accumulator overfilled");

   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> bit_cnt == '0)
      else $error("register write did not drop pending bits");

   // nothing is popped from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_count != '0)
      else $error("pop from empty symbol queue");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import mlkpc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE0 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE1 = 2'd3;
   localparam logic [1:0]           FMT_UNUSED = 2'd3;
   localparam int unsigned          SETTLE_CYCLES = 8;
   localparam int unsigned          CYCLE_LIMIT = 400000;
   localparam int unsigned          PHASE_ITEMS = 45;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             last;
   } word_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COEFF_W-1:0] req_coeff_in = '0;
   logic [BYTE_W-1:0]         req_byte_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [VAL_W-1:0]          rsp_value_out;
   logic                      rsp_last;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // shadow copy of the codec state
   logic        shadow_dir = DIR_ENCODE;
   logic [1:0]  shadow_fmt = FMT_PLAIN;
   logic [23:0] shadow_acc = '0;
   int unsigned shadow_cnt = 0;

   word_type    due_words[$];
   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned gap_max = 0;
   int unsigned stall_pct = 0;
   int unsigned ready_run = 0;

   mlkem_poly_compress_pack_codec u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_coeff_in  (req_coeff_in),
      .req_byte_in   (req_byte_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: runs of ready or stall, each of random length
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_run <= $urandom_range(1, 6);
         rsp_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
      end else begin
         ready_run <= ready_run - 1;
      end
   end

   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: value_out %03h last %0b",
                     $time, rsp_value_out, rsp_last);
         end else begin
            want = due_words.pop_front();
            if (rsp_value_out !== want.value) begin
               errors++;
               $display("%0t: value_out expected %03h actual %03h",
                        $time, want.value, rsp_value_out);
            end
            if (rsp_last !== want.last) begin
               errors++;
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
            end
         end
      end
   end

   function automatic int unsigned symbol_bits(input logic [1:0] fmt);
      case (fmt)
         FMT_DU10: return 10;
         FMT_DV4:  return 4;
         default:  return 12;
      endcase
   endfunction

   function automatic int unsigned mod_q(input logic signed [COEFF_W-1:0] c);
      int r;
      r = int'(c) % int'(Q_MOD);
      if (r < 0) r += int'(Q_MOD);
      return r;
   endfunction

   // one accepted item: push the bytes or coefficients it completes
   task automatic codec_step(input logic signed [COEFF_W-1:0] coeff,
                             input logic [BYTE_W-1:0] b);
      int unsigned d;
      int unsigned m;
      int unsigned t;
      word_type w;
      word_type fresh[$];
      d = symbol_bits(shadow_fmt);
      m = (1 << d) - 1;
      if (shadow_dir == DIR_ENCODE) begin
         t = mod_q(coeff);
         if (d != 12) t = (((t << d) + HALF_Q) / Q_MOD) & m;
         shadow_acc = shadow_acc | (24'(t) << shadow_cnt);
         shadow_cnt += d;
         while (shadow_cnt >= 8) begin
            w.value = {4'h0, shadow_acc[7:0]};
            w.last = 1'b0;
            fresh.push_back(w);
            shadow_acc = shadow_acc >> 8;
            shadow_cnt -= 8;
         end
      end else begin
         shadow_acc = shadow_acc | (24'(b) << shadow_cnt);
         shadow_cnt += 8;
         while (shadow_cnt >= d) begin
            t = shadow_acc & m;
            if (d != 12) t = (t * Q_MOD + (1 << (d - 1))) >> d;
            w.value = t[VAL_W-1:0];
            w.last = 1'b0;
            fresh.push_back(w);
            shadow_acc = shadow_acc >> d;
            shadow_cnt -= d;
         end
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[k]) due_words.push_back(fresh[k]);
   endtask

   task automatic send_item(input logic signed [COEFF_W-1:0] coeff,
                            input logic [BYTE_W-1:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_coeff_in <= coeff;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
      codec_step(coeff, b);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // a write to a real register drops any partial bits
      if (idx == REG_DIRECTION) begin
         shadow_dir = data[0];
         shadow_acc = '0;
         shadow_cnt = 0;
      end else if (idx == REG_FORMAT) begin
         shadow_fmt = data;
         shadow_acc = '0;
         shadow_cnt = 0;
      end
      @(posedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_words.size() != 0);
   endtask

   // items that complete no group may still be in flight, so wait out the latency too
   task automatic settle_pipeline();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [COEFF_W-1:0] pick_coeff();
      int k;
      logic signed [COEFF_W-1:0] c;
      case ($urandom_range(0, 3))
         0: c = COEFF_W'($urandom);
         1: c = COEFF_W'(int'($urandom_range(0, 64)) - 32);
         2: begin
            k = int'($urandom_range(0, 18)) - 9;
            c = COEFF_W'(k * int'(Q_MOD) + int'($urandom_range(0, 4)) - 2);
         end
         default: c = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      endcase
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      if ($urandom_range(0, 7) == 0) return {BYTE_W{$urandom_range(0, 1) == 1}};
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic test_encode_directed();
      write_csr(REG_DIRECTION, {1'b0, DIR_ENCODE});
      write_csr(REG_FORMAT, FMT_PLAIN);
      send_item(16'sh8000, pick_byte());
      send_item(16'sh7FFF, pick_byte());
      send_item(-16'sd1, pick_byte());
      send_item(16'sd3329, pick_byte());
      settle_pipeline();
      write_csr(REG_FORMAT, FMT_DU10);
      send_item(16'sd0, pick_byte());
      send_item(16'sd3328, pick_byte());
      send_item(16'sd1664, pick_byte());
      send_item(-16'sd1665, pick_byte());
      settle_pipeline();
      // 3328 rounds up to 16 and wraps to zero in four bits
      write_csr(REG_FORMAT, FMT_DV4);
      send_item(16'sd3328, pick_byte());
      send_item(16'sd1, pick_byte());
      settle_pipeline();
   endtask

   task automatic test_decode_directed();
      write_csr(REG_DIRECTION, {1'b0, DIR_DECODE});
      write_csr(REG_FORMAT, FMT_PLAIN);
      send_item(pick_coeff(), 8'hFF);
      send_item(pick_coeff(), 8'hFF);
      send_item(pick_coeff(), 8'hFF);
      send_item(pick_coeff(), 8'h00);
      settle_pipeline();
      write_csr(REG_FORMAT, FMT_DU10);
      send_item(pick_coeff(), 8'hFF);
      send_item(pick_coeff(), 8'h00);
      send_item(pick_coeff(), 8'hA5);
      send_item(pick_coeff(), 8'h5A);
      send_item(pick_coeff(), 8'hFF);
      settle_pipeline();
      write_csr(REG_FORMAT, FMT_DV4);
      send_item(pick_coeff(), 8'h0F);
      send_item(pick_coeff(), 8'hF0);
      settle_pipeline();
   endtask

   task automatic test_csr_side_effects();
      // upper data bit is not part of the direction register
      write_csr(REG_DIRECTION, {1'b1, DIR_ENCODE});
      write_csr(REG_FORMAT, FMT_DV4);
      send_item(16'sd1000, pick_byte());
      settle_pipeline();
      write_csr(REG_SPARE0, 2'd3);
      send_item(-16'sd7, pick_byte());
      send_item(16'sd2500, pick_byte());
      settle_pipeline();
      write_csr(REG_FORMAT, FMT_DV4);
      send_item(16'sd400, pick_byte());
      send_item(16'sd3000, pick_byte());
      settle_pipeline();
      write_csr(REG_DIRECTION, {1'b1, DIR_DECODE});
      write_csr(REG_FORMAT, FMT_UNUSED);
      send_item(pick_coeff(), 8'h3C);
      settle_pipeline();
      write_csr(REG_SPARE1, 2'd0);
      send_item(pick_coeff(), 8'hC3);
      settle_pipeline();
   endtask

   task automatic test_random_stream();
      logic [1:0] fmt_code;
      logic       dir_code;
      for (int p = 0; p < 16; p++) begin
         settle_pipeline();
         if (p % 4 == 0) begin
            gap_max = 0;
            stall_pct = 0;
         end else begin
            gap_max = $urandom_range(1, 8);
            stall_pct = $urandom_range(10, 70);
         end
         dir_code = (p % 2 == 1) ? DIR_DECODE : DIR_ENCODE;
         fmt_code = 2'(p / 4);
         write_csr(REG_DIRECTION, {1'($urandom_range(0, 1)), dir_code});
         write_csr(REG_FORMAT, fmt_code);
         if ($urandom_range(0, 3) == 0) begin
            write_csr(($urandom_range(0, 1) == 1) ? REG_SPARE1 : REG_SPARE0,
                      2'($urandom_range(0, 3)));
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 5 && i == 20) pause_until_drained();
            send_item(pick_coeff(), pick_byte());
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_encode_directed();
      test_decode_directed();
      test_csr_side_effects();
      test_random_stream();
      settle_pipeline();
      if (errors == 0 && due_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ mlkem_poly_compress_pack_codec.f @@
rtl/mlkpc_pkg.sv
rtl/mlkpc_front.sv
rtl/mlkpc_fifo.sv
rtl/mlkpc_back.sv
rtl/mlkem_poly_compress_pack_codec.sv
verif/tb_top.sv
